// ===== design/arcball_pkg.sv =====
// Shared widths, register indexes and stage-to-stage records for the arcball mapper.
// No dependencies; every other design file imports this package.
package arcball_pkg;

  // Coordinate and fraction widths
  localparam int COORD_W  = 12;
  localparam int FRAC_W   = 14;

  // Derived datapath widths
  localparam int MAG_W    = COORD_W + 1;        // |2x - w|, |h - 2y|
  localparam int PROD_W   = 2 * COORD_W + 1;    // a = mx*h, b = my*w, c = w*h
  localparam int SQ_W     = 2 * PROD_W;         // a^2, b^2, c^2
  localparam int NORM_W   = 31;                 // normalised direction, msb at bit 30
  localparam int NORM_TOP = NORM_W - 1;
  localparam int SH_W     = $clog2(NORM_W);     // normalising shift amount
  localparam int RAD_W    = 2 * NORM_W + 1;     // an^2 + bn^2
  localparam int ROOT_W   = 32;                 // floor(sqrt(an^2 + bn^2))
  localparam int LREM_W   = 2 * ROOT_W;         // remainder of the length root
  localparam int Q_W      = FRAC_W + 1;         // quotient / z magnitude, up to 1.0
  localparam int NUM_W    = NORM_W + FRAC_W + 2;
  localparam int DEN_W    = ROOT_W + 1;
  localparam int ZV_W     = 2 * FRAC_W + 1;     // 1 - x^2 - y^2 in Q1.28
  localparam int ZREM_W   = ZV_W + 1;
  localparam int XY_W     = 16;
  localparam int Z_W      = 15;
  localparam int CFG_ADDR_W = 1;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_VIEW_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_VIEW_HEIGHT = 1'b1;

  localparam logic [COORD_W-1:0] VIEW_WIDTH_RST  = COORD_W'(640);
  localparam logic [COORD_W-1:0] VIEW_HEIGHT_RST = COORD_W'(480);

  localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << FRAC_W;

  // Everything the later stages need from the front end
  typedef struct packed {
    logic               negx;
    logic               negy;
    logic               in_disk;
    logic [MAG_W-1:0]   mx;
    logic [MAG_W-1:0]   my;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
    logic [NORM_W-1:0]  an;
    logic [NORM_W-1:0]  bn;
  } arcball_side_t;

  // Planar result and its flags
  typedef struct packed {
    logic           negx;
    logic           negy;
    logic           in_disk;
    logic [Q_W-1:0] qx;
    logic [Q_W-1:0] qy;
  } arcball_res_t;

endpackage

// ===== design/arcball_front.sv =====
// Front end of the arcball mapper: centring, products, exact disk test and
// direction normalisation over five register stages. Uses arcball_pkg.
module arcball_front
  import arcball_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                ce,
  input  logic                in_vld,
  input  logic [COORD_W-1:0]  pixel_x,
  input  logic [COORD_W-1:0]  pixel_y,
  input  logic [COORD_W-1:0]  view_width,
  input  logic [COORD_W-1:0]  view_height,
  output logic                out_vld,
  output arcball_side_t       out_side,
  output logic [RAD_W-1:0]    out_rad
);

  logic vld1, vld2, vld3, vld4, vld5;
  arcball_side_t sd1, sd2, sd3, sd4, sd5;
  arcball_side_t sd1_next, sd3_next, sd4_next;
  logic [COORD_W-1:0] w_eff, h_eff;
  logic [MAG_W-1:0]   tx, ty, w13, h13;
  logic [PROD_W-1:0]  pa, pb, pc, pm;
  logic [SQ_W-1:0]    sqa, sqb, sqc;
  logic [2*NORM_W-1:0] sqan, sqbn;
  logic [RAD_W-1:0]   rad;
  logic [SH_W-1:0]    msb, shamt;

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
      vld5 <= 1'b0;
    end else if (ce) begin
      vld1 <= in_vld;
      vld2 <= vld1;
      vld3 <= vld2;
      vld4 <= vld3;
      vld5 <= vld4;
    end
  end

  // Stage 1: treat a zero size as one, centre and take magnitudes
  always_comb begin
    w_eff = (view_width == '0) ? COORD_W'(1) : view_width;
    h_eff = (view_height == '0) ? COORD_W'(1) : view_height;
    tx    = {pixel_x, 1'b0};
    ty    = {pixel_y, 1'b0};
    w13   = MAG_W'(w_eff);
    h13   = MAG_W'(h_eff);
    sd1_next      = '0;
    sd1_next.w    = w_eff;
    sd1_next.h    = h_eff;
    sd1_next.negx = tx < w13;
    sd1_next.mx   = (tx < w13) ? (w13 - tx) : (tx - w13);
    sd1_next.negy = ty > h13;
    sd1_next.my   = (ty > h13) ? (ty - h13) : (h13 - ty);
  end

  // Stage 3: find the leading one and scale the direction to bit 30
  always_comb begin
    pm  = (pa > pb) ? pa : pb;
    msb = '0;
    for (int i = 0; i < PROD_W; i++) begin
      if (pm[i]) msb = SH_W'(i);
    end
    shamt = SH_W'(NORM_TOP) - msb;
    sd3_next    = sd2;
    sd3_next.an = NORM_W'((PROD_W + NORM_W)'(pa) << shamt);
    sd3_next.bn = NORM_W'((PROD_W + NORM_W)'(pb) << shamt);
  end

  // Stage 4: exact disk test on integers
  always_comb begin
    sd4_next         = sd3;
    sd4_next.in_disk = ({1'b0, sqa} + {1'b0, sqb}) <= {1'b0, sqc};
  end

  // Hold the payload while stalled
  always_ff @(posedge clk) begin
    if (ce) begin
      sd1  <= sd1_next;
      sd2  <= sd1;
      pa   <= PROD_W'(sd1.mx) * PROD_W'(sd1.h);
      pb   <= PROD_W'(sd1.my) * PROD_W'(sd1.w);
      pc   <= PROD_W'(sd1.w) * PROD_W'(sd1.h);
      sd3  <= sd3_next;
      sqa  <= SQ_W'(pa) * SQ_W'(pa);
      sqb  <= SQ_W'(pb) * SQ_W'(pb);
      sqc  <= SQ_W'(pc) * SQ_W'(pc);
      sd4  <= sd4_next;
      sqan <= (2*NORM_W)'(sd3.an) * (2*NORM_W)'(sd3.an);
      sqbn <= (2*NORM_W)'(sd3.bn) * (2*NORM_W)'(sd3.bn);
      sd5  <= sd4;
      rad  <= RAD_W'(sqan) + RAD_W'(sqbn);
    end
  end

  assign out_vld  = vld5;
  assign out_side = sd5;
  assign out_rad  = rad;

endmodule

// ===== design/arcball_len_sqrt.sv =====
// Pipelined integer square root of the normalised squared length, one root
// bit per stage, with the front-end record carried alongside. Uses arcball_pkg.
module arcball_len_sqrt
  import arcball_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                ce,
  input  logic                in_vld,
  input  arcball_side_t       in_side,
  input  logic [RAD_W-1:0]    in_rad,
  output logic                out_vld,
  output arcball_side_t       out_side,
  output logic [ROOT_W-1:0]   out_len
);

  logic                vld  [1:ROOT_W];
  arcball_side_t       side [1:ROOT_W];
  logic [ROOT_W-1:0]   root [1:ROOT_W];
  logic [LREM_W-1:0]   rem  [1:ROOT_W-1];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;
    logic                v_in;
    arcball_side_t       s_in;
    logic [ROOT_W-1:0]   r_in;
    logic [LREM_W-1:0]   m_in;
    logic [LREM_W-1:0]   trial;
    logic                take;

    if (k == 0) begin : g_first
      assign v_in = in_vld;
      assign s_in = in_side;
      assign r_in = '0;
      assign m_in = LREM_W'(in_rad);
    end else begin : g_rest
      assign v_in = vld[k];
      assign s_in = side[k];
      assign r_in = root[k];
      assign m_in = rem[k];
    end

    // Try the next root bit
    assign trial = (LREM_W'(r_in) << (B + 1)) | (LREM_W'(1) << (2 * B));
    assign take  = m_in >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (ce) begin
        vld[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        side[k+1] <= s_in;
        root[k+1] <= take ? (r_in | (ROOT_W'(1) << B)) : r_in;
      end
    end

    // The last stage needs no remainder
    if (k < ROOT_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (ce) begin
          rem[k+1] <= take ? (m_in - trial) : m_in;
        end
      end
    end
  end

  assign out_vld  = vld[ROOT_W];
  assign out_side = side[ROOT_W];
  assign out_len  = root[ROOT_W];

endmodule

// ===== design/arcball_div.sv =====
// Two-lane pipelined restoring divider giving the rounded planar components,
// one quotient bit per stage. Uses arcball_pkg.
module arcball_div
  import arcball_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                ce,
  input  logic                in_vld,
  input  arcball_side_t       in_side,
  input  logic [ROOT_W-1:0]   in_len,
  output logic                out_vld,
  output arcball_res_t        out_res
);

  logic [NUM_W-1:0] num0 [2];
  logic [DEN_W-1:0] den0 [2];

  logic             vld [1:Q_W];
  arcball_res_t     flg [1:Q_W];
  logic [NUM_W-1:0] rem [2][1:Q_W-1];
  logic [DEN_W-1:0] den [2][1:Q_W-1];
  logic [Q_W-1:0]   quo [2][1:Q_W];

  // Pick the division: by the viewport inside the disk, by the length outside.
  // Numerator and denominator are doubled so that the floor rounds to nearest.
  always_comb begin
    if (in_side.in_disk) begin
      num0[0] = (NUM_W'(in_side.mx) << (FRAC_W + 1)) + NUM_W'(in_side.w);
      den0[0] = DEN_W'({in_side.w, 1'b0});
      num0[1] = (NUM_W'(in_side.my) << (FRAC_W + 1)) + NUM_W'(in_side.h);
      den0[1] = DEN_W'({in_side.h, 1'b0});
    end else begin
      num0[0] = (NUM_W'(in_side.an) << (FRAC_W + 1)) + NUM_W'(in_len);
      den0[0] = {in_len, 1'b0};
      num0[1] = (NUM_W'(in_side.bn) << (FRAC_W + 1)) + NUM_W'(in_len);
      den0[1] = {in_len, 1'b0};
    end
  end

  // Valid bits and flags
  for (genvar k = 0; k < Q_W; k++) begin : g_ctl
    arcball_res_t f_in;
    logic         v_in;
    if (k == 0) begin : g_first
      always_comb begin
        f_in         = '0;
        f_in.negx    = in_side.negx;
        f_in.negy    = in_side.negy;
        f_in.in_disk = in_side.in_disk;
      end
      assign v_in = in_vld;
    end else begin : g_rest
      assign f_in = flg[k];
      assign v_in = vld[k];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (ce) begin
        vld[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        flg[k+1] <= f_in;
      end
    end
  end

  // Quotient lanes
  for (genvar ln = 0; ln < 2; ln++) begin : g_lane
    for (genvar k = 0; k < Q_W; k++) begin : g_stage
      localparam int B = Q_W - 1 - k;
      logic [NUM_W-1:0] r_in;
      logic [DEN_W-1:0] d_in;
      logic [Q_W-1:0]   q_in;
      logic [NUM_W-1:0] trial;
      logic             take;

      if (k == 0) begin : g_first
        assign r_in = num0[ln];
        assign d_in = den0[ln];
        assign q_in = '0;
      end else begin : g_rest
        assign r_in = rem[ln][k];
        assign d_in = den[ln][k];
        assign q_in = quo[ln][k];
      end

      // Subtract the shifted divisor where it fits
      assign trial = NUM_W'(d_in) << B;
      assign take  = r_in >= trial;

      always_ff @(posedge clk) begin
        if (ce) begin
          quo[ln][k+1] <= take ? (q_in | (Q_W'(1) << B)) : q_in;
        end
      end

      if (k < Q_W - 1) begin : g_rem
        always_ff @(posedge clk) begin
          if (ce) begin
            rem[ln][k+1] <= take ? (r_in - trial) : r_in;
            den[ln][k+1] <= d_in;
          end
        end
      end
    end
  end

  always_comb begin
    out_res    = flg[Q_W];
    out_res.qx = quo[0][Q_W];
    out_res.qy = quo[1][Q_W];
  end

  assign out_vld = vld[Q_W];

endmodule

// ===== design/arcball_zsqrt.sv =====
// Height on the sphere: squares of the planar components, 1 - x^2 - y^2 and
// a pipelined rounded square root. Uses arcball_pkg.
module arcball_zsqrt
  import arcball_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                ce,
  input  logic                in_vld,
  input  arcball_res_t        in_res,
  output logic                out_vld,
  output arcball_res_t        out_res,
  output logic [Q_W-1:0]      out_z
);

  localparam logic [ZREM_W-1:0] ONE2 = ZREM_W'(1) << (2 * FRAC_W);

  logic              vlda, vldb;
  arcball_res_t      resa, resb;
  logic [2*Q_W-1:0]  sqx, sqy;
  logic [ZREM_W-1:0] ssum;
  logic [ZV_W-1:0]   vz;

  logic              vld  [1:Q_W];
  arcball_res_t      res  [1:Q_W];
  logic [Q_W-1:0]    root [1:Q_W];
  logic [ZREM_W-1:0] rem  [1:Q_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vlda <= 1'b0;
      vldb <= 1'b0;
    end else if (ce) begin
      vlda <= in_vld;
      vldb <= vlda;
    end
  end

  // Square the components, then take 1 - x^2 - y^2, floored at zero
  assign ssum = ZREM_W'(sqx) + ZREM_W'(sqy);

  always_ff @(posedge clk) begin
    if (ce) begin
      resa <= in_res;
      sqx  <= (2*Q_W)'(in_res.qx) * (2*Q_W)'(in_res.qx);
      sqy  <= (2*Q_W)'(in_res.qy) * (2*Q_W)'(in_res.qy);
      resb <= resa;
      vz   <= (ssum >= ONE2) ? '0 : ZV_W'(ONE2 - ssum);
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int B = Q_W - 1 - k;
    logic              v_in;
    arcball_res_t      s_in;
    logic [Q_W-1:0]    r_in;
    logic [ZREM_W-1:0] m_in;
    logic [ZREM_W-1:0] trial;
    logic              take;

    if (k == 0) begin : g_first
      assign v_in = vldb;
      assign s_in = resb;
      assign r_in = '0;
      assign m_in = ZREM_W'(vz);
    end else begin : g_rest
      assign v_in = vld[k];
      assign s_in = res[k];
      assign r_in = root[k];
      assign m_in = rem[k];
    end

    // Try the next root bit
    assign trial = (ZREM_W'(r_in) << (B + 1)) | (ZREM_W'(1) << (2 * B));
    assign take  = m_in >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (ce) begin
        vld[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        res[k+1]  <= s_in;
        root[k+1] <= take ? (r_in | (Q_W'(1) << B)) : r_in;
        rem[k+1]  <= take ? (m_in - trial) : m_in;
      end
    end
  end

  // Round to nearest: step up when the remainder exceeds the root
  assign out_z   = (rem[Q_W] > ZREM_W'(root[Q_W])) ? (root[Q_W] + Q_W'(1)) : root[Q_W];
  assign out_vld = vld[Q_W];
  assign out_res = res[Q_W];

endmodule

// ===== design/arcball_screen_to_sphere_unit.sv =====
// Arcball mapper: turns a pointer position in pixels into a point on a unit
// sphere centred on the viewport, as signed Q1.14 x and y, unsigned Q1.14 z
// and a flag that says whether the point fell inside the unit disk (outside
// it the planar vector is scaled to unit length and z is zero). One request
// is taken every clock unless the output stalls; each result passes through
// five front-end stages, the 32-stage length square root, the 15-stage
// divider, two squaring stages and the 15-stage height square root, and the
// output register. The whole pipeline holds while a result waits at the
// output. Write the viewport registers only while no request is in flight.
// Uses arcball_pkg and the arcball_front, _len_sqrt, _div and _zsqrt stages.
module arcball_screen_to_sphere_unit
  import arcball_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [COORD_W-1:0]     cfg_wdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [2*COORD_W-1:0]   s_tdata,   // pixel_x, pixel_y
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [47:0]            m_tdata,   // unit_x, unit_y, unit_z, zero pad
  output logic                   m_tuser    // inside_disk
);

  logic [COORD_W-1:0] view_width, view_height;
  logic               ce;
  logic               fe_vld, ls_vld, dv_vld, zs_vld;
  arcball_side_t      fe_side, ls_side;
  logic [RAD_W-1:0]   fe_rad;
  logic [ROOT_W-1:0]  ls_len;
  arcball_res_t       dv_res, zs_res;
  logic [Q_W-1:0]     zs_z, qx_c, qy_c;
  logic [XY_W-1:0]    unit_x, unit_y, ux_next, uy_next;
  logic [Z_W-1:0]     unit_z;
  logic               inside_disk;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      view_width  <= VIEW_WIDTH_RST;
      view_height <= VIEW_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_VIEW_WIDTH:  view_width  <= cfg_wdata;
        REG_VIEW_HEIGHT: view_height <= cfg_wdata;
        default:         ;
      endcase
    end
  end

  // Advance every stage unless a result is stuck at the output
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  arcball_front u_front (
    .clk         (clk),
    .rst         (rst),
    .ce          (ce),
    .in_vld      (s_tvalid),
    .pixel_x     (s_tdata[COORD_W-1:0]),
    .pixel_y     (s_tdata[2*COORD_W-1:COORD_W]),
    .view_width  (view_width),
    .view_height (view_height),
    .out_vld     (fe_vld),
    .out_side    (fe_side),
    .out_rad     (fe_rad)
  );

  arcball_len_sqrt u_len_sqrt (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_vld   (fe_vld),
    .in_side  (fe_side),
    .in_rad   (fe_rad),
    .out_vld  (ls_vld),
    .out_side (ls_side),
    .out_len  (ls_len)
  );

  arcball_div u_div (
    .clk     (clk),
    .rst     (rst),
    .ce      (ce),
    .in_vld  (ls_vld),
    .in_side (ls_side),
    .in_len  (ls_len),
    .out_vld (dv_vld),
    .out_res (dv_res)
  );

  arcball_zsqrt u_zsqrt (
    .clk     (clk),
    .rst     (rst),
    .ce      (ce),
    .in_vld  (dv_vld),
    .in_res  (dv_res),
    .out_vld (zs_vld),
    .out_res (zs_res),
    .out_z   (zs_z)
  );

  // Clamp to one and restore the signs
  always_comb begin
    qx_c    = (zs_res.qx > ONE_Q) ? ONE_Q : zs_res.qx;
    qy_c    = (zs_res.qy > ONE_Q) ? ONE_Q : zs_res.qy;
    ux_next = zs_res.negx ? (XY_W'(0) - XY_W'(qx_c)) : XY_W'(qx_c);
    uy_next = zs_res.negy ? (XY_W'(0) - XY_W'(qy_c)) : XY_W'(qy_c);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ce) begin
      m_tvalid <= zs_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      unit_x      <= ux_next;
      unit_y      <= uy_next;
      unit_z      <= zs_res.in_disk ? Z_W'(zs_z) : '0;
      inside_disk <= zs_res.in_disk;
    end
  end

  assign m_tdata = {1'b0, unit_z, unit_y, unit_x};
  assign m_tuser = inside_disk;

  // A waiting result must hold off new requests
  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("request accepted while output stalled");

  // The output register takes exactly what the last stage offered
  a_valid_follows: assert property (@(posedge clk) disable iff (rst)
    ce |=> m_tvalid == $past(zs_vld))
    else $error("output valid lost or invented");

  // Components stay within plus or minus one
  a_xy_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(unit_x) >= -16'sd16384) && ($signed(unit_x) <= 16'sd16384) &&
                 ($signed(unit_y) >= -16'sd16384) && ($signed(unit_y) <= 16'sd16384))
    else $error("planar component out of range");

  // Outside the disk z is zero and the direction is not
  a_outside_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (unit_z == '0) && ((unit_x != '0) || (unit_y != '0)))
    else $error("outside result malformed");

endmodule

// ===== sim/arcball_checker.sv =====
// Checker for the arcball mapper: predicts each result from the accepted request
// and compares it with the output stream. Depends on arcball_pkg.
`timescale 1ns / 100ps

module arcball_checker
  import arcball_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [COORD_W-1:0]    cfg_wdata,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [2*COORD_W-1:0]  s_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [47:0]           m_tdata,
  input  logic                  m_tuser,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic [15:0] ux;
    logic [15:0] uy;
    logic [14:0] uz;
    logic        in_disk;
  } sphere_pt_t;

  logic [COORD_W-1:0] view_w, view_h;
  sphere_pt_t         sphere_q[$];

  assign pending = sphere_q.size();

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] round_div(logic [63:0] n, logic [63:0] d);
    return (2 * n + d) / (2 * d);
  endfunction

  // Map one pixel position onto the sphere
  function automatic sphere_pt_t map_to_sphere(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
    sphere_pt_t  p;
    logic [63:0] w, h, mx, my, a, b, m, len, qx, qy, qz, s, v, r;
    logic [127:0] sa, sb, sc;
    logic        nx, ny;
    w  = (view_w == 0) ? 1 : view_w;
    h  = (view_h == 0) ? 1 : view_h;
    nx = 2 * px < w;
    ny = h < 2 * py;
    mx = nx ? w - 2 * px : 2 * px - w;
    my = ny ? 2 * py - h : h - 2 * py;
    a  = mx * h;
    b  = my * w;
    sa = 128'(a) * 128'(a);
    sb = 128'(b) * 128'(b);
    sc = 128'(w * h) * 128'(w * h);
    qz = 0;
    p.in_disk = (sa + sb) <= sc;
    if (p.in_disk) begin
      qx = round_div(mx << FRAC_W, w);
      qy = round_div(my << FRAC_W, h);
      s  = qx * qx + qy * qy;
      v  = (s >= (64'd1 << 2 * FRAC_W)) ? 0 : (64'd1 << 2 * FRAC_W) - s;
      r  = int_sqrt(v);
      if (v - r * r > r) r++;
      qz = r;
    end else begin
      m = (a > b) ? a : b;
      while (m >= (64'd1 << 31)) begin
        a >>= 1; b >>= 1; m >>= 1;
      end
      while (m < (64'd1 << 30)) begin
        a <<= 1; b <<= 1; m <<= 1;
      end
      len = int_sqrt(a * a + b * b);
      qx  = round_div(a << FRAC_W, len);
      qy  = round_div(b << FRAC_W, len);
      if (qx > ONE_Q) qx = ONE_Q;
      if (qy > ONE_Q) qy = ONE_Q;
    end
    p.ux = nx ? 16'(-qx) : 16'(qx);
    p.uy = ny ? 16'(-qy) : 16'(qy);
    p.uz = 15'(qz);
    return p;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("checker: %s mismatch, got %0h expected %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // Track registers, queue predictions, compare results
  always @(posedge clk) begin
    sphere_pt_t e;
    if (rst) begin
      view_w     <= VIEW_WIDTH_RST;
      view_h     <= VIEW_HEIGHT_RST;
      fail_count = 0;
      sphere_q.delete();
    end else begin
      if (cfg_we && cfg_addr == REG_VIEW_WIDTH) view_w <= cfg_wdata;
      if (cfg_we && cfg_addr == REG_VIEW_HEIGHT) view_h <= cfg_wdata;
      if (s_tvalid && s_tready)
        sphere_q.push_back(map_to_sphere(s_tdata[11:0], s_tdata[23:12]));
      if (m_tvalid && m_tready) begin
        if (sphere_q.size() == 0) begin
          report("unexpected result", m_tdata[31:0], 32'd0);
        end else begin
          e = sphere_q.pop_front();
          if (m_tdata[15:0] !== e.ux) report("unit_x", 32'(m_tdata[15:0]), 32'(e.ux));
          if (m_tdata[31:16] !== e.uy) report("unit_y", 32'(m_tdata[31:16]), 32'(e.uy));
          if (m_tdata[46:32] !== e.uz) report("unit_z", 32'(m_tdata[46:32]), 32'(e.uz));
          if (m_tuser !== e.in_disk)
            report("inside_disk", 32'(m_tuser), 32'(e.in_disk));
        end
      end
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// Top of the arcball mapper testbench: clock, reset, register writes and
// pointer requests with random idling. Depends on arcball_pkg and arcball_checker.
`timescale 1ns / 100ps

module tb_top;
  import arcball_pkg::*;

  localparam int LATENCY   = 70;
  localparam int MAX_CYCLE = 400000;

  logic                  clk = 0;
  logic                  rst = 1;
  logic                  cfg_we = 0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [COORD_W-1:0]    cfg_wdata = '0;
  logic                  s_tvalid = 0;
  logic                  s_tready;
  logic [2*COORD_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 0;
  logic [47:0]           m_tdata;
  logic                  m_tuser;
  int                    fail_count, pending;
  int                    cycle = 0;
  bit                    calm = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  arcball_screen_to_sphere_unit uut (.*);
  arcball_checker chk (.*);

  // Timeout
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Receiver stalls in bursts
  initial begin
    int n;
    while (1) begin
      @(posedge clk);
      if (!calm && $urandom_range(3) == 0) begin
        m_tready <= 0;
        n = $urandom_range(14, 1);
        repeat (n) @(posedge clk);
      end
      m_tready <= 1;
    end
  end

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [COORD_W-1:0] v);
    cfg_we    <= 1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // Send one request, possibly after an idle burst
  task automatic send_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
    int n;
    if (!calm && $urandom_range(4) == 0) begin
      s_tvalid <= 0;
      n = $urandom_range(14, 1);
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= {py, px};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Random points, mostly on the viewport, some anywhere
  task automatic random_points(int count, int w, int h);
    repeat (count) begin
      if ($urandom_range(3) == 0)
        send_point(COORD_W'($urandom), COORD_W'($urandom));
      else
        send_point(COORD_W'($urandom_range(w)), COORD_W'($urandom_range(h)));
    end
  endtask

  initial begin
    int w, h;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: centre, corners, disk edge, extremes at reset viewport
    send_point(320, 240);
    send_point(0, 0);
    send_point(639, 479);
    send_point(4095, 4095);
    send_point(0, 4095);
    send_point(4095, 0);
    send_point(0, 240);
    send_point(640, 240);
    send_point(320, 0);
    send_point(320, 480);
    send_point(546, 240);
    send_point(12'hAAA, 12'h555);
    send_point(12'h555, 12'hAAA);
    drain();
    // Zero registers count as one
    write_reg(REG_VIEW_WIDTH, 0);
    write_reg(REG_VIEW_HEIGHT, 0);
    send_point(0, 0);
    send_point(1, 1);
    send_point(4095, 4095);
    drain();
    write_reg(REG_VIEW_WIDTH, 4095);
    write_reg(REG_VIEW_HEIGHT, 4095);
    send_point(2047, 2048);
    send_point(4095, 0);
    send_point(0, 4095);
    drain();
    // Random phases across viewport sizes
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin w = 1; h = 4095; end
        1: begin w = 4095; h = 1; end
        2: begin w = 640; h = 480; end
        default: begin w = $urandom_range(4095, 1); h = $urandom_range(4095, 1); end
      endcase
      write_reg(REG_VIEW_WIDTH, COORD_W'(w));
      write_reg(REG_VIEW_HEIGHT, COORD_W'(h));
      if (ph == 5) calm = 1;
      random_points(90, w, h);
      drain();
    end
    repeat (LATENCY) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/arcball_pkg.sv
design/arcball_front.sv
design/arcball_len_sqrt.sv
design/arcball_div.sv
design/arcball_zsqrt.sv
design/arcball_screen_to_sphere_unit.sv
sim/arcball_checker.sv
sim/tb_top.sv
